### rtl/core/wildcard_glob_matcher_unit_macros.svh
// Assertion macros shared by the glob matcher RTL.
`ifndef WILDCARD_GLOB_MATCHER_UNIT_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glob matcher check failed");

// The consequent must hold in the cycle after the antecedent.
`define GMU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glob matcher check failed");

`endif

### rtl/core/gmu_pkg.sv
// ----------------------------------------------------------------------------
// Glob matcher package
// Shared widths, codes, wildcard characters and case folding.
// ----------------------------------------------------------------------------
package gmu_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int BYTE_W          = 8;
  localparam int OPCODE_W        = 2;
  localparam int POS_W           = 5;
  localparam int LEN_CFG_W       = 6;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 6;

  localparam logic [BYTE_W-1:0] CH_ANY  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOLD_CASE      = 1'd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_SUBJECT = 2'd1,
    OP_EMPTY   = 2'd2
  } op_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                   input logic en);
    logic [BYTE_W-1:0] r;
    r = b;
    if (en && b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

### rtl/core/gmu_in_if.sv
// ----------------------------------------------------------------------------
// Glob matcher input channel
// Valid/ready channel carrying one pattern load, subject or empty beat.
// ----------------------------------------------------------------------------
interface gmu_in_if
  import gmu_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [POS_W-1:0]    position;
  logic [BYTE_W-1:0]   byte_value;
  logic                last;

  modport source (output valid, output opcode, output position, output byte_value,
                  output last, input ready);
  modport sink (input valid, input opcode, input position, input byte_value,
                input last, output ready);
endinterface

### rtl/core/gmu_out_if.sv
// ----------------------------------------------------------------------------
// Glob matcher result channel
// Valid/ready channel carrying one match verdict.
// ----------------------------------------------------------------------------
interface gmu_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink (input valid, input matched, output ready);
endinterface

### rtl/core/gmu_pat_store.sv
// ----------------------------------------------------------------------------
// Glob matcher pattern store
// Holds the pattern bytes and classifies every position against a subject byte.
// ----------------------------------------------------------------------------
module gmu_pat_store
  import gmu_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [POS_W-1:0]       wr_pos,
  input  logic [BYTE_W-1:0]      wr_byte,
  input  logic [LEN_W-1:0]       used_len,
  input  logic                   fold_case,
  input  logic [BYTE_W-1:0]      subj_byte,
  output logic [MAX_PATTERN-1:0] star_v,
  output logic [MAX_PATTERN-1:0] adv_v
);

  localparam int AW   = ($clog2(MAX_PATTERN) > 0) ? $clog2(MAX_PATTERN) : 1;
  localparam int PX_W = (LEN_W > POS_W) ? LEN_W : POS_W;

  logic [BYTE_W-1:0] store_r [MAX_PATTERN];
  logic [PX_W-1:0]   pos_ext;
  logic [BYTE_W-1:0] subj_fold;

  assign pos_ext   = PX_W'(wr_pos);
  assign subj_fold = fold_byte(subj_byte, fold_case);

  always_ff @(posedge clk) begin
    if (wr_en && (pos_ext < PX_W'(MAX_PATTERN))) begin
      store_r[pos_ext[AW-1:0]] <= wr_byte;
    end
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
    logic in_use;
    logic is_star;
    assign in_use  = LEN_W'(i) < used_len;
    assign is_star = store_r[i] == CH_STAR;
    assign star_v[i] = in_use && is_star;
    assign adv_v[i]  = in_use && !is_star &&
                       ((store_r[i] == CH_ANY) ||
                        (fold_byte(store_r[i], fold_case) == subj_fold));
  end

endmodule

### rtl/core/gmu_step.sv
// ----------------------------------------------------------------------------
// Glob matcher position step
// Moves the live position set over one subject byte, before star closure.
// ----------------------------------------------------------------------------
module gmu_step
  import gmu_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic [MAX_PATTERN:0]   live,
  input  logic [MAX_PATTERN-1:0] star_v,
  input  logic [MAX_PATTERN-1:0] adv_v,
  output logic [MAX_PATTERN:0]   next_set
);

  logic [MAX_PATTERN-1:0] stay;
  logic [MAX_PATTERN-1:0] move;

  assign stay     = live[MAX_PATTERN-1:0] & star_v;
  assign move     = live[MAX_PATTERN-1:0] & adv_v;
  assign next_set = {1'b0, stay} | {move, 1'b0};

endmodule

### rtl/core/gmu_star_close.sv
// ----------------------------------------------------------------------------
// Glob matcher star closure
// Spreads live positions forward over runs of '*' with a parallel prefix.
// ----------------------------------------------------------------------------
module gmu_star_close
  import gmu_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic [MAX_PATTERN:0]   seed,
  input  logic [MAX_PATTERN-1:0] star_v,
  output logic [MAX_PATTERN:0]   closed
);

  localparam int W = MAX_PATTERN + 1;

  logic [W-1:0] gen;
  logic [W-1:0] prop;

  always_comb begin
    gen  = seed;
    prop = {star_v, 1'b0};
    for (int d = 1; d < W; d = d * 2) begin
      for (int j = W - 1; j >= d; j--) begin
        gen[j]  = gen[j] | (prop[j] & gen[j-d]);
        prop[j] = prop[j] & prop[j-d];
      end
    end
    closed = gen;
  end

endmodule

### rtl/core/wildcard_glob_matcher_unit.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher
// Streams subject bytes against a stored '?' and '*' pattern.
//
// Channel   Dir  Payload                               Beat
// in_if     in   opcode, position, byte_value, last    valid & ready
// out_if    out  matched                               valid & ready
// cfg_*     in   cfg_index, cfg_wdata                  cfg_we
//
// One beat per cycle is accepted while no stalled result holds the input register.
// A verdict is offered once its beat has passed the input register and the result register.
// Reset is synchronous and leaves an empty pattern with case folding off.
// A stalled result holds the input register only when that beat carries a result.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit
  import gmu_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  gmu_in_if.sink                 in_if,
  gmu_out_if.source              out_if,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  `include "wildcard_glob_matcher_unit_macros.svh"

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CW    = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;

  logic                 s1_valid_r;
  op_t                  s1_op_r;
  logic [POS_W-1:0]     s1_pos_r;
  logic [BYTE_W-1:0]    s1_byte_r;
  logic                 s1_last_r;
  logic                 s1_has_res;
  logic                 s1_fire;
  logic                 out_free;

  logic [LEN_CFG_W-1:0] len_r;
  logic                 fold_r;
  logic                 restart_r;
  logic [MAX_PATTERN:0] live_r;

  logic                 out_valid_r;
  logic                 matched_r;
  logic                 matched_nxt;

  logic [LEN_W-1:0]       used_len;
  logic [MAX_PATTERN-1:0] star_v;
  logic [MAX_PATTERN-1:0] adv_v;
  logic [MAX_PATTERN:0]   start_set;
  logic [MAX_PATTERN:0]   cur_set;
  logic [MAX_PATTERN:0]   next_set;
  logic [MAX_PATTERN:0]   closed_set;

  assign used_len = (CW'(len_r) > CW'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : LEN_W'(len_r);

  assign s1_has_res = (s1_op_r == OP_EMPTY) || ((s1_op_r == OP_SUBJECT) && s1_last_r);
  assign out_free   = !out_valid_r || out_if.ready;
  assign s1_fire    = s1_valid_r && (!s1_has_res || out_free);
  assign in_if.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_op_r   <= op_t'(in_if.opcode);
      s1_pos_r  <= in_if.position;
      s1_byte_r <= in_if.byte_value;
      s1_last_r <= in_if.last;
    end
  end

  gmu_pat_store #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (s1_fire && (s1_op_r == OP_LOAD)),
    .wr_pos    (s1_pos_r),
    .wr_byte   (s1_byte_r),
    .used_len  (used_len),
    .fold_case (fold_r),
    .subj_byte (s1_byte_r),
    .star_v    (star_v),
    .adv_v     (adv_v)
  );

  gmu_star_close #(.MAX_PATTERN(MAX_PATTERN)) u_start_close (
    .seed   ({{MAX_PATTERN{1'b0}}, 1'b1}),
    .star_v (star_v),
    .closed (start_set)
  );

  assign cur_set = restart_r ? start_set : live_r;

  gmu_step #(.MAX_PATTERN(MAX_PATTERN)) u_step (
    .live     (cur_set),
    .star_v   (star_v),
    .adv_v    (adv_v),
    .next_set (next_set)
  );

  gmu_star_close #(.MAX_PATTERN(MAX_PATTERN)) u_next_close (
    .seed   (next_set),
    .star_v (star_v),
    .closed (closed_set)
  );

  assign matched_nxt = (s1_op_r == OP_EMPTY) ? start_set[used_len] : closed_set[used_len];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      fold_r    <= 1'b0;
      restart_r <= 1'b1;
    end else begin
      if (cfg_we && (cfg_index == CFG_PATTERN_LENGTH)) begin
        len_r     <= cfg_wdata[LEN_CFG_W-1:0];
        restart_r <= 1'b1;
      end
      if (cfg_we && (cfg_index == CFG_FOLD_CASE)) begin
        fold_r <= cfg_wdata[0];
      end
      if (s1_fire) begin
        unique case (s1_op_r)
          OP_LOAD: begin
            restart_r <= 1'b1;
          end
          OP_SUBJECT: begin
            restart_r <= s1_last_r;
          end
          OP_EMPTY: begin
            restart_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_op_r == OP_SUBJECT)) begin
      live_r <= closed_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_res) begin
      matched_r <= matched_nxt;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.matched = matched_r;

  `GMU_ASSERT_SAME(a_stall_blocks_input, s1_valid_r && s1_has_res && out_valid_r && !out_if.ready, !in_if.ready)
  `GMU_ASSERT_NEXT(a_result_restarts, s1_fire && s1_has_res, restart_r)
  `GMU_ASSERT_SAME(a_result_has_source, $rose(out_valid_r), $past(s1_fire && s1_has_res))

endmodule

### verif/wildcard_glob_matcher_unit_test.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher unit test
// Loads '?' and '*' patterns into the matcher, streams subject strings through
// it under changing length and case-folding settings, and checks every match
// verdict against the bench's bit-parallel position-set predictor or a pinned value.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gmu_pkg::*;

  localparam int ITEM_TARGET    = 1550;
  localparam int CALM_TAIL      = 150;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PAT_SLOTS      = MAX_PATTERN_DEF;
  localparam int LEN_MAX        = (1 << LEN_CFG_W) - 1;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [PAT_SLOTS:0]  START_SET = 1;
  localparam logic [BYTE_W-1:0]   LETTERS [4] = '{"a", "b", "A", "B"};

  typedef enum {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [OPCODE_W-1:0]    opcode;
    logic [POS_W-1:0]       position;
    logic [BYTE_W-1:0]      value;
    logic                   last;
    bit                     pinned;
    bit                     pin_verdict;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  gmu_in_if  in_ch ();
  gmu_out_if out_ch ();

  logic [BYTE_W-1:0]    pat_mem [PAT_SLOTS];
  logic [PAT_SLOTS:0]   live_set;
  logic [LEN_CFG_W-1:0] len_reg;
  logic                 fold_reg;

  bit   expected_verdicts [$];
  int   fail_count;
  int   beats_sent;
  int   idle_cycles;
  int   stall_left;
  int   tx_gap_pct;
  int   rx_stall_pct;
  bit   calm_run;

  wildcard_glob_matcher_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int unsigned used_count();
    return (len_reg > PAT_SLOTS) ? PAT_SLOTS : int'(len_reg);
  endfunction

  function automatic logic [PAT_SLOTS:0] star_closure(input logic [PAT_SLOTS:0] s);
    logic [PAT_SLOTS:0] r;
    r = s;
    for (int i = 0; i < used_count(); i++) begin
      if (r[i] && pat_mem[i] == CH_STAR) begin
        r[i+1] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] lower_if_folding(input logic [BYTE_W-1:0] c);
    if (fold_reg && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic void restart_positions();
    live_set = star_closure(START_SET);
  endfunction

  function automatic void match_step(input logic [OPCODE_W-1:0] op,
                                     input logic [POS_W-1:0] pos,
                                     input logic [BYTE_W-1:0] value,
                                     input logic last,
                                     output bit has_verdict,
                                     output bit verdict);
    logic [PAT_SLOTS:0] next_set;
    logic [BYTE_W-1:0]  p;
    has_verdict = 1'b0;
    verdict     = 1'b0;
    case (op)
      OP_LOAD: begin
        pat_mem[pos] = value;
        restart_positions();
      end
      OP_SUBJECT: begin
        next_set = '0;
        for (int i = 0; i < used_count(); i++) begin
          if (live_set[i]) begin
            p = pat_mem[i];
            if (p == CH_STAR) begin
              next_set[i] = 1'b1;
            end else if (p == CH_ANY || lower_if_folding(p) == lower_if_folding(value)) begin
              next_set[i+1] = 1'b1;
            end
          end
        end
        live_set = star_closure(next_set);
        if (last) begin
          has_verdict = 1'b1;
          verdict     = live_set[used_count()];
          restart_positions();
        end
      end
      OP_EMPTY: begin
        restart_positions();
        has_verdict = 1'b1;
        verdict     = live_set[used_count()];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PATTERN_LENGTH: begin
        len_reg = data[LEN_CFG_W-1:0];
        restart_positions();
      end
      CFG_FOLD_CASE: begin
        fold_reg = data[0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_letter();
    return LETTERS[$urandom_range(0, 3)];
  endfunction

  function automatic logic [BYTE_W-1:0] pick_subject_byte();
    if ($urandom_range(0, 3) == 0) begin
      return BYTE_W'($urandom_range(0, 255));
    end
    return pick_letter();
  endfunction

  function automatic logic [BYTE_W-1:0] pick_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1: return CH_STAR;
      2, 3: return CH_ANY;
      4: return BYTE_W'($urandom_range(0, 255));
      default: return pick_letter();
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 8;
      default: return 30;
    endcase
  endfunction

  function automatic stim_row_t beat_row(input logic [OPCODE_W-1:0] op,
                                         input logic [POS_W-1:0] pos,
                                         input logic [BYTE_W-1:0] value,
                                         input logic last);
    stim_row_t row;
    row.kind        = ROW_BEAT;
    row.opcode      = op;
    row.position    = pos;
    row.value       = value;
    row.last        = last;
    row.pinned      = 1'b0;
    row.pin_verdict = 1'b0;
    row.reg_index   = CFG_PATTERN_LENGTH;
    row.reg_data    = '0;
    return row;
  endfunction

  function automatic stim_row_t pinned_row(input logic [OPCODE_W-1:0] op,
                                           input logic [POS_W-1:0] pos,
                                           input logic [BYTE_W-1:0] value,
                                           input logic last,
                                           input bit verdict);
    stim_row_t row;
    row             = beat_row(op, pos, value, last);
    row.pinned      = 1'b1;
    row.pin_verdict = verdict;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row           = beat_row(OP_LOAD, '0, '0, 1'b0);
    row.kind      = ROW_REG;
    row.reg_index = idx;
    row.reg_data  = data;
    return row;
  endfunction

  task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [BYTE_W-1:0] value, input logic last,
                           input bit pinned, input bit pin_verdict);
    bit has_verdict;
    bit verdict;
    if (!calm_run && $urandom_range(0, 99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.position   <= pos;
    in_ch.byte_value <= value;
    in_ch.last       <= last;
    do @(posedge clk); while (!in_ch.ready);
    match_step(op, pos, value, last, has_verdict, verdict);
    if (has_verdict) begin
      expected_verdicts.push_back(pinned ? pin_verdict : verdict);
    end
    if (op != OP_UNUSED) begin
      beats_sent++;
    end
    calm_run = (beats_sent >= ITEM_TARGET - CALM_TAIL);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  task automatic send_subject();
    logic [BYTE_W-1:0] text [$];
    logic [BYTE_W-1:0] p;
    logic [BYTE_W-1:0] folded;
    for (int i = 0; i < used_count(); i++) begin
      p      = pat_mem[i];
      folded = p | CASE_OFFSET;
      if (p == CH_STAR) begin
        repeat ($urandom_range(0, 3)) text.push_back(pick_subject_byte());
      end else if (p == CH_ANY) begin
        text.push_back(BYTE_W'($urandom_range(0, 255)));
      end else if (folded >= (CH_UPPER_A | CASE_OFFSET) &&
                   folded <= (CH_UPPER_Z | CASE_OFFSET) && $urandom_range(0, 3) == 0) begin
        text.push_back(p ^ CASE_OFFSET);
      end else begin
        text.push_back(p);
      end
    end
    case ($urandom_range(0, 5))
      0: begin
        if (text.size() > 0) begin
          text[$urandom_range(0, text.size() - 1)] = pick_subject_byte();
        end
      end
      1: text.push_back(pick_subject_byte());
      2: begin
        if (text.size() > 0) begin
          void'(text.pop_back());
        end
      end
      default: begin
      end
    endcase
    if (text.size() == 0 || $urandom_range(0, 9) == 0) begin
      send_beat(OP_EMPTY, POS_W'($urandom_range(0, 31)), BYTE_W'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'b0, 1'b0);
      return;
    end
    foreach (text[i]) begin
      if (!calm_run && $urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 2))
          0: send_beat(OP_LOAD, POS_W'($urandom_range(0, 31)), pick_pattern_byte(),
                       1'($urandom_range(0, 1)), 1'b0, 1'b0);
          1: send_beat(OP_UNUSED, POS_W'($urandom_range(0, 31)),
                       BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
          default: send_beat(OP_EMPTY, POS_W'($urandom_range(0, 31)),
                             BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'b0, 1'b0);
        endcase
      end
      send_beat(OP_SUBJECT, POS_W'($urandom_range(0, 31)), text[i], i == text.size() - 1,
                1'b0, 1'b0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (calm_run) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_verdict
    bit want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("matched: expected no beat, actual %0b", out_ch.matched);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_ch.matched !== want) begin
          $error("matched: expected %0b, actual %0b", want, out_ch.matched);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("wildcard_glob_matcher_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   directed_rows [$];
    int unsigned new_len;
    int          phase;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_PATTERN_LENGTH;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_LOAD;
    in_ch.position   = '0;
    in_ch.byte_value = '0;
    in_ch.last       = 1'b0;
    fail_count       = 0;
    beats_sent       = 0;
    idle_cycles      = 0;
    calm_run         = 1'b0;
    tx_gap_pct       = 20;
    rx_stall_pct     = 20;
    len_reg          = '0;
    fold_reg         = 1'b0;
    restart_positions();

    directed_rows.push_back(pinned_row(OP_EMPTY, '0, '0, 1'b0, 1'b1));
    directed_rows.push_back(pinned_row(OP_SUBJECT, '0, 8'h00, 1'b1, 1'b0));
    directed_rows.push_back(beat_row(OP_SUBJECT, '1, 8'hFF, 1'b0));
    directed_rows.push_back(pinned_row(OP_EMPTY, '0, '0, 1'b0, 1'b1));
    directed_rows.push_back(beat_row(OP_UNUSED, '1, 8'hFF, 1'b1));
    directed_rows.push_back(beat_row(OP_LOAD, 5'd0, CH_UPPER_A, 1'b0));
    directed_rows.push_back(beat_row(OP_LOAD, 5'd1, CH_STAR, 1'b0));
    directed_rows.push_back(beat_row(OP_LOAD, 5'd2, CH_ANY, 1'b1));
    directed_rows.push_back(beat_row(OP_LOAD, 5'd3, "z", 1'b0));
    directed_rows.push_back(beat_row(OP_LOAD, '1, 8'hFF, 1'b1));
    directed_rows.push_back(reg_row(CFG_PATTERN_LENGTH, 6'd4));
    directed_rows.push_back(beat_row(OP_SUBJECT, '0, "A", 1'b0));
    directed_rows.push_back(beat_row(OP_SUBJECT, '0, "x", 1'b0));
    directed_rows.push_back(beat_row(OP_SUBJECT, '0, "y", 1'b0));
    directed_rows.push_back(beat_row(OP_SUBJECT, '0, "z", 1'b1));
    directed_rows.push_back(beat_row(OP_SUBJECT, '0, "a", 1'b0));
    directed_rows.push_back(beat_row(OP_SUBJECT, '0, "q", 1'b0));
    directed_rows.push_back(beat_row(OP_SUBJECT, '0, "z", 1'b1));
    directed_rows.push_back(reg_row(CFG_FOLD_CASE, 6'd1));
    directed_rows.push_back(beat_row(OP_SUBJECT, '0, "a", 1'b0));
    directed_rows.push_back(beat_row(OP_SUBJECT, '0, "q", 1'b0));
    directed_rows.push_back(beat_row(OP_SUBJECT, '0, "Z", 1'b1));
    directed_rows.push_back(pinned_row(OP_EMPTY, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(beat_row(OP_LOAD, 5'd0, CH_STAR, 1'b0));
    directed_rows.push_back(reg_row(CFG_PATTERN_LENGTH, 6'd1));
    directed_rows.push_back(pinned_row(OP_EMPTY, '0, '0, 1'b0, 1'b1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_REG) begin
        write_reg(directed_rows[r].reg_index, directed_rows[r].reg_data);
      end else begin
        send_beat(directed_rows[r].opcode, directed_rows[r].position, directed_rows[r].value,
                  directed_rows[r].last, directed_rows[r].pinned, directed_rows[r].pin_verdict);
      end
    end

    // Every store entry below the new length is loaded before the length is written.
    phase = 0;
    while (beats_sent < ITEM_TARGET) begin
      tx_gap_pct   = pick_idle_pct();
      rx_stall_pct = pick_idle_pct();
      case (phase)
        0: new_len = PAT_SLOTS;
        1: new_len = LEN_MAX;
        2: new_len = 0;
        3: new_len = 1;
        default: begin
          case ($urandom_range(0, 9))
            0: new_len = 0;
            1: new_len = $urandom_range(9, PAT_SLOTS);
            2: new_len = $urandom_range(PAT_SLOTS + 1, LEN_MAX);
            default: new_len = $urandom_range(1, 8);
          endcase
        end
      endcase
      for (int i = 0; i < ((new_len > PAT_SLOTS) ? PAT_SLOTS : new_len); i++) begin
        send_beat(OP_LOAD, POS_W'(i), pick_pattern_byte(), 1'($urandom_range(0, 1)),
                  1'b0, 1'b0);
      end
      write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(new_len));
      if (phase < 4) begin
        write_reg(CFG_FOLD_CASE, CFG_DATA_W'(phase % 2));
      end else if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_FOLD_CASE, CFG_DATA_W'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(6, 16)) begin
        if (beats_sent < ITEM_TARGET) begin
          send_subject();
        end
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("wildcard_glob_matcher_unit test passed");
    end else begin
      $display("wildcard_glob_matcher_unit test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/gmu_pkg.sv
rtl/core/gmu_in_if.sv
rtl/core/gmu_out_if.sv
rtl/core/gmu_pat_store.sv
rtl/core/gmu_step.sv
rtl/core/gmu_star_close.sv
rtl/core/wildcard_glob_matcher_unit.sv
verif/wildcard_glob_matcher_unit_test.sv
